[hdl/erfc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths and pipeline latencies for the erfc pipeline.
// Used by every module of the block; depends on nothing else.
package erfc_pkg;

    localparam int ARG_W        = 16;
    localparam int OUT_W        = 18;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int QB           = 30;
    localparam int IN_FRAC_DEF  = 12;
    localparam int OUT_FRAC_DEF = 16;

    localparam int T_W    = 31;
    localparam int QUO_W  = 32;
    localparam int Z_W    = 34;
    localparam int E_W    = 31;
    localparam int R_W    = 30;
    localparam int SQ_W   = 45;
    localparam int N_W    = 5;
    localparam int EXP_TERMS = 12;
    localparam int H_STEPS   = 5;
    localparam int RED_STG   = 3;

    function automatic longint unsigned q_of_nano(input longint unsigned m);
        return ((m << 31) / 64'd1000000000 + 64'd1) >> 1;
    endfunction

    localparam logic [28:0] P_Q   = 29'(q_of_nano(64'd327591100));
    localparam logic [29:0] LN2_Q = 30'd744261118;
    localparam logic [R_W+4:0] BIG_LIM = 35'(64'd31 * 64'd744261118);

    // Horner coefficients: first the leading one, then one added per step.
    function automatic logic signed [Z_W-1:0] h_coef(input int j);
        logic signed [Z_W-1:0] v;
        v = '0;
        unique case (j)
            0: v = Z_W'($signed({1'b0, q_of_nano(64'd1061405429)}));
            1: v = -Z_W'($signed({1'b0, q_of_nano(64'd1453152027)}));
            2: v = Z_W'($signed({1'b0, q_of_nano(64'd1421413741)}));
            3: v = -Z_W'($signed({1'b0, q_of_nano(64'd284496736)}));
            4: v = Z_W'($signed({1'b0, q_of_nano(64'd254829592)}));
            default: v = '0;
        endcase
        return v;
    endfunction

    localparam int LAT_T = 3 + QUO_W;
    localparam int LAT_H = 2 * H_STEPS;
    localparam int LAT_E = 3 + RED_STG + 3 * EXP_TERMS;

endpackage

[hdl/erfc_recip.sv]
`timescale 1ns / 1ps
// Reciprocal stage: t = 1/(1 + p*|x|) in Q30 through a bit-per-stage divider.
// Depends on erfc_pkg.
module erfc_recip import erfc_pkg::*; #(
    parameter int IN_FRAC_BITS = IN_FRAC_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ARG_W-1:0] i_mag,
    output logic [T_W-1:0]   o_t
);

    localparam int PR_W  = 29 + ARG_W;
    localparam int DEN_W = PR_W + 1;
    localparam int REM_W = 62;
    localparam int CMP_W = DEN_W + QUO_W;

    logic [PR_W-1:0]  r_prod;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] prod_rnd;
    logic [REM_W-1:0] r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_dd  [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic [T_W-1:0]   r_t;

    assign prod_rnd = (DEN_W'(r_prod) + (DEN_W'(1) << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PR_W'(P_Q) * PR_W'(i_mag);
            r_den  <= (DEN_W'(1) << QB) + prod_rnd;
        end
    end

    assign r_rem[0] = REM_W'(1) << 61;
    assign r_dd[0]  = r_den;
    assign r_q[0]   = '0;

    for (genvar s = 0; s < QUO_W; s++) begin : g_div
        localparam int B = QUO_W - 1 - s;
        logic [CMP_W-1:0] sh;
        logic [REM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_q;
        logic [REM_W-1:0] rem_q;
        logic [DEN_W-1:0] dd_q;
        logic [QUO_W-1:0] q_q;

        always_comb begin
            sh    = CMP_W'(r_dd[s]) << B;
            n_rem = r_rem[s];
            n_q   = r_q[s];
            if (CMP_W'(r_rem[s]) >= sh) begin
                n_rem = r_rem[s] - REM_W'(sh);
                n_q   = r_q[s] | (QUO_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rem_q <= n_rem;
                dd_q  <= r_dd[s];
                q_q   <= n_q;
            end
        end

        assign r_rem[s+1] = rem_q;
        assign r_dd[s+1]  = dd_q;
        assign r_q[s+1]   = q_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= T_W'(((QUO_W+1)'(r_q[QUO_W]) + (QUO_W+1)'(1)) >> 1);
        end
    end

    assign o_t = r_t;

endmodule

[hdl/erfc_horner.sv]
`timescale 1ns / 1ps
// Fifth-degree Horner polynomial in t, two register stages per step.
// Depends on erfc_pkg.
module erfc_horner import erfc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [T_W-1:0] i_t,
    output logic [T_W-1:0] o_poly
);

    localparam int PM_W = T_W + Z_W - 1;

    logic signed [Z_W-1:0] z_s [H_STEPS+1];
    logic [T_W-1:0]        t_s [H_STEPS+1];

    assign z_s[0] = h_coef(0);
    assign t_s[0] = i_t;

    for (genvar j = 0; j < H_STEPS; j++) begin : g_step
        logic [PM_W-1:0]       r_pm;
        logic                  r_ng;
        logic [T_W-1:0]        r_ta;
        logic [T_W-1:0]        r_tb;
        logic signed [Z_W-1:0] r_z;
        logic [Z_W-2:0]        zmag;
        logic [Z_W-1:0]        m;
        logic signed [Z_W-1:0] val;
        logic signed [Z_W-1:0] n_z;

        assign zmag = z_s[j][Z_W-1] ? (Z_W-1)'(-z_s[j]) : (Z_W-1)'(z_s[j]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pm <= PM_W'(t_s[j]) * PM_W'(zmag);
                r_ng <= z_s[j][Z_W-1];
                r_ta <= t_s[j];
            end
        end

        always_comb begin
            m   = Z_W'((r_pm + (PM_W'(1) << (QB - 1))) >> QB);
            val = r_ng ? -$signed(m) : $signed(m);
            if (j < H_STEPS - 1) begin
                n_z = h_coef(j + 1) + val;
            end else begin
                n_z = val[Z_W-1] ? '0 : val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z  <= n_z;
                r_tb <= r_ta;
            end
        end

        assign z_s[j+1] = r_z;
        assign t_s[j+1] = r_tb;
    end

    assign o_poly = T_W'(z_s[H_STEPS]);

endmodule

[hdl/erfc_exp.sv]
`timescale 1ns / 1ps
// exp(-x*x) in Q30: square, ln2 range reduction, twelve series stages, final shift.
// Depends on erfc_pkg.
module erfc_exp import erfc_pkg::*; #(
    parameter int IN_FRAC_BITS = IN_FRAC_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ARG_W-1:0] i_mag,
    output logic [E_W-1:0]   o_ex
);

    localparam int SQP_W = 2 * ARG_W;
    localparam int SH_W  = SQP_W + 24;
    localparam int SH    = 2 * IN_FRAC_BITS - 6;
    localparam int RS_W  = 35;
    localparam int RP_W  = RS_W + 11;
    localparam logic [10:0] INV_LN2 = 11'((64'd1 << 40) / 64'd744261118);

    logic [SQP_W-1:0] r_sqp;
    logic [SQ_W-1:0]  r_sq;
    logic [SH_W-1:0]  sq_wide;

    assign sq_wide = ((SH_W'(r_sqp) << 24) + (SH_W'(1) << (SH - 1))) >> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqp <= SQP_W'(i_mag) * SQP_W'(i_mag);
            r_sq  <= SQ_W'(sq_wide);
        end
    end

    // Range reduction: n = floor(sq / ln2) from a reciprocal product, then one correction.
    logic [RP_W-1:0] r_rp;
    logic [RS_W-1:0] r_rs;
    logic            r_rbig;
    logic [N_W:0]    n_est;
    logic [RS_W-1:0] r_r0;
    logic [N_W:0]    r_ne;
    logic            r_r0big;
    logic [R_W-1:0]  n_rr;
    logic [N_W-1:0]  n_rn;
    logic [R_W-1:0]  r_rr;
    logic [N_W-1:0]  r_rn;
    logic            r_rrbig;

    assign n_est = (N_W+1)'(r_rp >> 40);

    always_comb begin
        n_rr = R_W'(r_r0);
        n_rn = N_W'(r_ne);
        if (r_r0 >= RS_W'(LN2_Q)) begin
            n_rr = R_W'(r_r0 - RS_W'(LN2_Q));
            n_rn = N_W'(r_ne + (N_W+1)'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp    <= RP_W'(r_sq[RS_W-1:0]) * RP_W'(INV_LN2);
            r_rs    <= r_sq[RS_W-1:0];
            r_rbig  <= (r_sq >= SQ_W'(BIG_LIM));
            r_r0    <= r_rs - RS_W'(RS_W'(n_est) * RS_W'(LN2_Q));
            r_ne    <= n_est;
            r_r0big <= r_rbig;
            r_rr    <= n_rr;
            r_rn    <= n_rn;
            r_rrbig <= r_r0big;
        end
    end

    // Nested series e = 1 - r/k * e, k from twelve down to one.
    logic [R_W-1:0] s_r   [EXP_TERMS+1];
    logic [N_W-1:0] s_n   [EXP_TERMS+1];
    logic           s_big [EXP_TERMS+1];
    logic [E_W-1:0] s_e   [EXP_TERMS+1];

    assign s_r[0]   = r_rr;
    assign s_n[0]   = r_rn;
    assign s_big[0] = r_rrbig;
    assign s_e[0]   = E_W'(1) << QB;

    for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
        localparam int K = EXP_TERMS - i;
        localparam logic [32:0] M = 33'((64'd1 << 32) / K);
        localparam int PR_W = R_W + E_W;
        localparam int X_W  = 32;
        localparam int Y_W  = X_W + 33;

        logic [PR_W-1:0] r_pr;
        logic [X_W-1:0]  r_x;
        logic [Y_W-1:0]  r_y;
        logic [R_W-1:0]  r_ra, r_rb, r_rc;
        logic [N_W-1:0]  r_na, r_nb, r_nc;
        logic            r_ba, r_bb, r_bc;
        logic [E_W-1:0]  r_e;
        logic [X_W-1:0]  x;
        logic [X_W-1:0]  q0;
        logic [X_W-1:0]  rem;
        logic [X_W-1:0]  q;
        logic [E_W-1:0]  n_e;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr <= PR_W'(s_r[i]) * PR_W'(s_e[i]);
                r_ra <= s_r[i];
                r_na <= s_n[i];
                r_ba <= s_big[i];
            end
        end

        assign x = X_W'((r_pr + (PR_W'(1) << (QB - 1))) >> QB) + X_W'(K / 2);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x  <= x;
                r_y  <= Y_W'(x) * Y_W'(M);
                r_rb <= r_ra;
                r_nb <= r_na;
                r_bb <= r_ba;
            end
        end

        always_comb begin
            q0  = X_W'(r_y >> 32);
            rem = r_x - X_W'(q0 * X_W'(K));
            q   = (rem >= X_W'(K)) ? q0 + X_W'(1) : q0;
            n_e = (q >= (X_W'(1) << QB)) ? '0 : E_W'((X_W'(1) << QB) - q);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e  <= n_e;
                r_rc <= r_rb;
                r_nc <= r_nb;
                r_bc <= r_bb;
            end
        end

        assign s_r[i+1]   = r_rc;
        assign s_n[i+1]   = r_nc;
        assign s_big[i+1] = r_bc;
        assign s_e[i+1]   = r_e;
    end

    logic [E_W:0]   e_dbl;
    logic [E_W-1:0] r_ex;

    assign e_dbl = {s_e[EXP_TERMS], 1'b0} >> s_n[EXP_TERMS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex <= s_big[EXP_TERMS] ? '0 : E_W'((e_dbl + (E_W+1)'(1)) >> 1);
        end
    end

    assign o_ex = r_ex;

endmodule

[hdl/erfc_approximation.sv]
`timescale 1ns / 1ps
// Top level of the erfc pipeline: input register, reciprocal, Horner, exp, final stages.
// Depends on erfc_pkg, erfc_recip, erfc_horner and erfc_exp.
//
//  Channel   Direction  Payload
//  s         in         tdata[15:0] arg_x, signed Q4.12
//  m         out        tdata[17:0] erfc_value, unsigned Q2.16
//
// One argument enters every cycle while the output is not stalled; results leave in order.
// The depth is set by the 32-stage reciprocal divider followed by the Horner chain.
// Reset clears only the valid bits; the data registers are not reset.
// When the output register is full and not taken, every stage holds and o_s_tready falls.
module erfc_approximation import erfc_pkg::*; #(
    parameter int IN_FRAC_BITS  = IN_FRAC_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] arg_x
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [17:0] erfc_value, rest zero
);

    localparam int LAT_PE = LAT_T + LAT_H;
    localparam int EX_DLY = LAT_PE - LAT_E;
    localparam int SO     = QB - OUT_FRAC_BITS;
    localparam int FP_W   = T_W + E_W;
    localparam int RES_W  = 33;
    localparam longint unsigned LIM_RAW = 64'd2 << OUT_FRAC_BITS;
    localparam logic [RES_W-1:0] LIM =
        RES_W'((LIM_RAW > 64'h3FFFF) ? 64'h3FFFF : LIM_RAW);

    logic en;
    logic [ARG_W-1:0] r_mag;
    logic             r_v0, r_n0;
    logic [T_W-1:0]   t;
    logic [T_W-1:0]   poly;
    logic [E_W-1:0]   ex;
    logic             r_vd [LAT_PE];
    logic             r_nd [LAT_PE];
    logic [E_W-1:0]   r_xd [EX_DLY];
    logic [FP_W-1:0]  r_fp;
    logic             r_fv, r_fn;
    logic [RES_W-1:0] r_res;
    logic             r_rv;
    logic [RES_W-1:0] res_m;
    logic [RES_W-1:0] n_res;
    logic [RES_W-1:0] o_rnd;
    logic [OUT_W-1:0] r_out;
    logic             r_ov;

    assign en         = ~r_ov | i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag <= i_s_tdata[ARG_W-1] ? ARG_W'(-i_s_tdata) : i_s_tdata;
            r_n0  <= i_s_tdata[ARG_W-1];
        end
    end

    erfc_recip #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_recip (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_mag),
        .o_t   (t)
    );

    erfc_horner u_horner (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_t    (t),
        .o_poly (poly)
    );

    erfc_exp #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_exp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_mag),
        .o_ex  (ex)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd[0] <= r_n0;
            r_xd[0] <= ex;
            for (int k = 1; k < LAT_PE; k++) begin
                r_nd[k] <= r_nd[k-1];
            end
            for (int k = 1; k < EX_DLY; k++) begin
                r_xd[k] <= r_xd[k-1];
            end
            r_fp <= FP_W'(poly) * FP_W'(r_xd[EX_DLY-1]);
            r_fn <= r_nd[LAT_PE-1];
            r_res <= n_res;
            r_out <= OUT_W'((o_rnd > LIM) ? LIM : o_rnd);
        end
    end

    assign res_m = RES_W'((r_fp + (FP_W'(1) << (QB - 1))) >> QB);

    always_comb begin
        n_res = res_m;
        if (r_fn) begin
            n_res = (res_m >= (RES_W'(1) << (QB + 1))) ? '0
                                                       : (RES_W'(1) << (QB + 1)) - res_m;
        end
    end

    assign o_rnd = (r_res + (RES_W'(1) << (SO - 1))) >> SO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 0; k < LAT_PE; k++) begin
                r_vd[k] <= 1'b0;
            end
            r_fv <= 1'b0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v0    <= i_s_tvalid;
            r_vd[0] <= r_v0;
            for (int k = 1; k < LAT_PE; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_fv <= r_vd[LAT_PE-1];
            r_rv <= r_fv;
            r_ov <= r_rv;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_W)'(0), r_out};

endmodule
